[rtl/plcl_pkg.sv]
package plcl_pkg;

   localparam int QUERY_W = 7;
   localparam int COUNT_W = 7;
   localparam int LABEL_W = 7;
   localparam int SUM_W = 8;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_COMPUTE = 2'd1;
   localparam logic [1:0] MODE_LABEL = 2'd2;
   localparam logic [1:0] MODE_SUM = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD2,
      ST_QRD,
      ST_RESP,
      ST_INIT,
      ST_SRD0,
      ST_SRD1,
      ST_SRD2,
      ST_SRD3,
      ST_SRD4,
      ST_JOIN,
      ST_FIND_P,
      ST_FIND_G,
      ST_LAB_START,
      ST_LAB_RD,
      ST_LAB_SUM
   } state_type;

   // Who asked for the current root search.
   typedef enum logic [1:0] {
      FR_A,
      FR_B,
      FR_K
   } find_ret_type;

endpackage

[rtl/plcl_ram.sv]
module plcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/periodic_lattice_cluster_labeler.sv]
// Cluster labeler for a periodic brick lattice of ROWS x COLS sites.
// Input channel (req_*): one beat per command. Mode load writes the next site in
// row-major order and gives no result; a site with two spins also passes through
// LOAD2 to write its second spin (one spin-value memory write port). Mode compute
// runs union-find over the loaded lattice and returns the cluster count, or just
// the old count mid-load; mode label and mode sum read one entry in QRD, register
// the result in RESP once the output register is free, then return to idle.
// Result channel (rsp_*): one beat per compute or query, held in an output
// register, so the block takes the next command while a result waits. A result
// that is ready while the previous one is still stalled waits inside the block.
// Compute seeds the parent memory in INIT, fetches each site's neighborhood in
// SRD0 to SRD4, tries each of its two bonds in JOIN, walks every root search
// through FIND_P and FIND_G, and labels and sums each spin densely through
// LAB_START, FIND_P, LAB_RD and, for a spin that is not a root, LAB_SUM. The
// parent memory has one read and one write port, and its registered read sets
// the pace of each search step.
// Reset empties the lattice pointer, the spin count and the cluster count; the
// memories are not cleared and are valid only after a load and a compute.
module periodic_lattice_cluster_labeler #(
   parameter int ROWS = 10,
   parameter int COLS = 6,
   parameter int MAX_SPINS = 120
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic              req_merged,
   input  logic              req_spin_first,
   input  logic              req_spin_second,
   input  logic              req_bond_even,
   input  logic              req_bond_odd,
   input  logic [6:0]        req_query_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_cluster_count,
   output logic [6:0]        rsp_spin_label,
   output logic signed [7:0] rsp_cluster_sum
);

   localparam int NSITES = ROWS * COLS;
   localparam int SITE_W = $clog2(NSITES);
   localparam int TOT_W = $clog2(2 * NSITES + 1);
   localparam int IW = $clog2(MAX_SPINS);
   localparam int NW = $clog2(MAX_SPINS + 1);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLS);
   localparam int SUMW = $clog2(MAX_SPINS + 1) + 1;
   localparam int XW0 = (TOT_W > NW) ? TOT_W : NW;
   localparam int XW = (XW0 > plcl_pkg::QUERY_W) ? XW0 : plcl_pkg::QUERY_W;
   localparam int SINFO_W = TOT_W + 3;

   plcl_pkg::state_type    state_ff, state_in, adv_state;
   plcl_pkg::find_ret_type fret_ff, fret_in;

   logic [SITE_W-1:0]  load_ptr_ff, load_ptr_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [NW-1:0]      clusters_ff, clusters_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [NW-1:0]      n_ff, n_in, k_ff, k_in, cnt_ff, cnt_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [SITE_W-1:0]  base_r_ff, base_r_in, base_n_ff, base_n_in;
   logic               bsel_ff, bsel_in;
   logic [SINFO_W-1:0] rj_ff, rj_in, nj_ff, nj_in, rjn_ff, rjn_in, njn_ff, njn_in;
   logic [IW-1:0]      x_ff, x_in, ra_ff, ra_in, root_ff, root_in, lbl_ff, lbl_in;
   logic               v_ff, v_in;
   logic [1:0]         mode_ff, mode_in;
   logic [6:0]         q_ff, q_in;
   logic               spin2_ff, spin2_in;
   logic [6:0]         pend_label_ff, pend_label_in;
   logic [7:0]         pend_sum_ff, pend_sum_in;
   logic [6:0]         rsp_count_ff, rsp_count_in, rsp_label_ff, rsp_label_in;
   logic [7:0]         rsp_sum_ff, rsp_sum_in;

   logic               site_we;
   logic [SITE_W-1:0]  site_wa, site_ra;
   logic [SINFO_W-1:0] site_wd, site_rd;
   logic               val_we, val_wd, val_rd;
   logic [IW-1:0]      val_wa, val_ra;
   logic               par_we;
   logic [IW-1:0]      par_wa, par_wd, par_ra, par_rd;
   logic               lab_we;
   logic [IW-1:0]      lab_wa, lab_wd, lab_ra, lab_rd;
   logic               sum_we;
   logic [IW-1:0]      sum_wa, sum_ra;
   logic signed [SUMW-1:0] sum_wd, sum_rd, v_now, v_old;

   logic               req_fire, rsp_free;
   logic [XW-1:0]      q_x, qff_x, total_x, n_x, max_x, clusters_x, load_base_x, lab_x;
   logic [TOT_W-1:0]   load_base;
   logic               col_last, row_last;
   logic [COL_W-1:0]   col_next;
   logic [SITE_W-1:0]  addr_rj, addr_nj, addr_rjn, addr_njn;
   logic [XW-1:0]      a_rj, b_rj, a_nj, b_nj, a_rjn, a_njn, ja_x, jb_x;
   logic [IW-1:0]      ja_i, jb_i, k_i;
   logic               bond_bit, join_ok, root_hit, k_lt_n;
   logic signed [15:0] sum_sx;
   logic [7:0]         sum_sat;

   assign req_fire = req_valid & req_ready;
   assign req_ready = (state_ff == plcl_pkg::ST_IDLE);
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   assign q_x = XW'(req_query_index);
   assign qff_x = XW'(q_ff);
   assign total_x = XW'(total_ff);
   assign n_x = XW'(n_ff);
   assign max_x = XW'(MAX_SPINS);
   assign clusters_x = XW'(clusters_ff);
   assign load_base = (load_ptr_ff == '0) ? '0 : total_ff;
   assign load_base_x = XW'(load_base);
   assign lab_x = XW'(lab_rd);

   assign col_last = (col_ff == COL_W'(COLS - 1));
   assign row_last = (row_ff == ROW_W'(ROWS - 1));
   assign col_next = col_last ? '0 : col_ff + COL_W'(1);
   assign addr_rj = base_r_ff + SITE_W'(col_ff);
   assign addr_nj = base_n_ff + SITE_W'(col_ff);
   assign addr_rjn = base_r_ff + SITE_W'(col_next);
   assign addr_njn = base_n_ff + SITE_W'(col_next);

   // Site word: first spin index, merged flag, odd bond, even bond.
   assign a_rj = XW'(rj_ff[SINFO_W-1:3]);
   assign b_rj = a_rj + XW'(!rj_ff[2]);
   assign a_nj = XW'(nj_ff[SINFO_W-1:3]);
   assign b_nj = a_nj + XW'(!nj_ff[2]);
   assign a_rjn = XW'(rjn_ff[SINFO_W-1:3]);
   assign a_njn = XW'(njn_ff[SINFO_W-1:3]);

   // Even rows lean right within their row, odd rows lean right toward the next row.
   always_comb begin
      if (!row_ff[0]) begin
         ja_x = bsel_ff ? b_nj : a_nj;
         jb_x = bsel_ff ? a_rjn : b_rj;
      end else begin
         ja_x = bsel_ff ? b_rj : b_nj;
         jb_x = bsel_ff ? a_njn : a_rj;
      end
   end

   assign ja_i = ja_x[IW-1:0];
   assign jb_i = jb_x[IW-1:0];
   assign k_i = k_ff[IW-1:0];
   assign bond_bit = bsel_ff ? rj_ff[1] : rj_ff[0];
   assign join_ok = bond_bit && (ja_x < n_x) && (jb_x < n_x);
   assign root_hit = (par_rd == x_ff);
   assign k_lt_n = (k_ff < n_ff);

   assign v_now = val_rd ? {SUMW{1'b1}} : SUMW'(1);
   assign v_old = v_ff ? {SUMW{1'b1}} : SUMW'(1);
   assign sum_sx = 16'(sum_rd);

   always_comb begin
      if (sum_sx > 16'sd127) begin
         sum_sat = 8'h7f;
      end else if (sum_sx < -16'sd128) begin
         sum_sat = 8'h80;
      end else begin
         sum_sat = sum_sx[7:0];
      end
   end

   always_comb begin
      if (!bsel_ff) begin
         adv_state = plcl_pkg::ST_JOIN;
      end else if (col_last && row_last) begin
         adv_state = plcl_pkg::ST_LAB_START;
      end else begin
         adv_state = plcl_pkg::ST_SRD0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plcl_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  plcl_pkg::MODE_LOAD:
                     state_in = req_merged ? plcl_pkg::ST_IDLE : plcl_pkg::ST_LOAD2;
                  plcl_pkg::MODE_COMPUTE:
                     state_in = (load_ptr_ff == '0) ? plcl_pkg::ST_INIT : plcl_pkg::ST_RESP;
                  default: state_in = plcl_pkg::ST_QRD;
               endcase
            end
         end
         plcl_pkg::ST_LOAD2: state_in = plcl_pkg::ST_IDLE;
         plcl_pkg::ST_QRD: state_in = plcl_pkg::ST_RESP;
         plcl_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = plcl_pkg::ST_IDLE;
            end
         end
         plcl_pkg::ST_INIT: state_in = k_lt_n ? plcl_pkg::ST_INIT : plcl_pkg::ST_SRD0;
         plcl_pkg::ST_SRD0: state_in = plcl_pkg::ST_SRD1;
         plcl_pkg::ST_SRD1: state_in = plcl_pkg::ST_SRD2;
         plcl_pkg::ST_SRD2: state_in = plcl_pkg::ST_SRD3;
         plcl_pkg::ST_SRD3: state_in = plcl_pkg::ST_SRD4;
         plcl_pkg::ST_SRD4: state_in = plcl_pkg::ST_JOIN;
         plcl_pkg::ST_JOIN: state_in = join_ok ? plcl_pkg::ST_FIND_P : adv_state;
         plcl_pkg::ST_FIND_P: begin
            if (!root_hit) begin
               state_in = plcl_pkg::ST_FIND_G;
            end else begin
               case (fret_ff)
                  plcl_pkg::FR_A: state_in = plcl_pkg::ST_FIND_P;
                  plcl_pkg::FR_B: state_in = adv_state;
                  default: state_in = plcl_pkg::ST_LAB_RD;
               endcase
            end
         end
         plcl_pkg::ST_FIND_G: state_in = plcl_pkg::ST_FIND_P;
         plcl_pkg::ST_LAB_START:
            state_in = k_lt_n ? plcl_pkg::ST_FIND_P : plcl_pkg::ST_RESP;
         plcl_pkg::ST_LAB_RD:
            state_in = (root_ff == k_i) ? plcl_pkg::ST_LAB_START : plcl_pkg::ST_LAB_SUM;
         plcl_pkg::ST_LAB_SUM: state_in = plcl_pkg::ST_LAB_START;
         default: state_in = plcl_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      fret_in = fret_ff;
      load_ptr_in = load_ptr_ff;
      total_in = total_ff;
      clusters_in = clusters_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      n_in = n_ff;
      k_in = k_ff;
      cnt_in = cnt_ff;
      row_in = row_ff;
      col_in = col_ff;
      base_r_in = base_r_ff;
      base_n_in = base_n_ff;
      bsel_in = bsel_ff;
      rj_in = rj_ff;
      nj_in = nj_ff;
      rjn_in = rjn_ff;
      njn_in = njn_ff;
      x_in = x_ff;
      ra_in = ra_ff;
      root_in = root_ff;
      lbl_in = lbl_ff;
      v_in = v_ff;
      mode_in = mode_ff;
      q_in = q_ff;
      spin2_in = spin2_ff;
      pend_label_in = pend_label_ff;
      pend_sum_in = pend_sum_ff;
      rsp_count_in = rsp_count_ff;
      rsp_label_in = rsp_label_ff;
      rsp_sum_in = rsp_sum_ff;
      site_we = 1'b0;
      site_wa = '0;
      site_wd = '0;
      site_ra = '0;
      val_we = 1'b0;
      val_wa = '0;
      val_wd = 1'b0;
      val_ra = '0;
      par_we = 1'b0;
      par_wa = '0;
      par_wd = '0;
      par_ra = '0;
      lab_we = 1'b0;
      lab_wa = '0;
      lab_wd = '0;
      lab_ra = '0;
      sum_we = 1'b0;
      sum_wa = '0;
      sum_wd = '0;
      sum_ra = '0;

      case (state_ff)
         plcl_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_in = req_mode;
               q_in = req_query_index;
               spin2_in = req_spin_second;
               case (req_mode)
                  plcl_pkg::MODE_LOAD: begin
                     site_we = 1'b1;
                     site_wa = load_ptr_ff;
                     site_wd = {load_base, req_merged, req_bond_odd, req_bond_even};
                     val_we = (load_base_x < max_x);
                     val_wa = load_base_x[IW-1:0];
                     val_wd = req_spin_first;
                     total_in = load_base + TOT_W'(1);
                     load_ptr_in = (load_ptr_ff == SITE_W'(NSITES - 1)) ? '0 :
                                   load_ptr_ff + SITE_W'(1);
                  end
                  plcl_pkg::MODE_COMPUTE: begin
                     pend_label_in = '0;
                     pend_sum_in = '0;
                     n_in = (total_x < max_x) ? total_x[NW-1:0] : NW'(MAX_SPINS);
                     k_in = '0;
                  end
                  plcl_pkg::MODE_LABEL: lab_ra = q_x[IW-1:0];
                  default: sum_ra = q_x[IW-1:0];
               endcase
            end
         end
         plcl_pkg::ST_LOAD2: begin
            val_we = (total_x < max_x);
            val_wa = total_x[IW-1:0];
            val_wd = spin2_ff;
            total_in = total_ff + TOT_W'(1);
         end
         plcl_pkg::ST_QRD: begin
            pend_label_in = ((mode_ff == plcl_pkg::MODE_LABEL) && (qff_x < total_x) &&
                             (qff_x < max_x)) ? lab_x[6:0] : '0;
            pend_sum_in = ((mode_ff == plcl_pkg::MODE_SUM) && (qff_x < clusters_x) &&
                           (qff_x < max_x)) ? sum_sat : '0;
         end
         plcl_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = clusters_x[6:0];
               rsp_label_in = pend_label_ff;
               rsp_sum_in = pend_sum_ff;
            end
         end
         plcl_pkg::ST_INIT: begin
            if (k_lt_n) begin
               par_we = 1'b1;
               par_wa = k_i;
               par_wd = k_i;
               k_in = k_ff + NW'(1);
            end else begin
               row_in = '0;
               col_in = '0;
               base_r_in = '0;
               base_n_in = SITE_W'(COLS);
            end
         end
         plcl_pkg::ST_SRD0: site_ra = addr_rj;
         plcl_pkg::ST_SRD1: begin
            rj_in = site_rd;
            site_ra = addr_nj;
         end
         plcl_pkg::ST_SRD2: begin
            nj_in = site_rd;
            site_ra = addr_rjn;
         end
         plcl_pkg::ST_SRD3: begin
            rjn_in = site_rd;
            site_ra = addr_njn;
         end
         plcl_pkg::ST_SRD4: begin
            njn_in = site_rd;
            bsel_in = 1'b0;
         end
         plcl_pkg::ST_FIND_G: begin
            // Path halving: point x at its grandparent and move there.
            par_we = 1'b1;
            par_wa = x_ff;
            par_wd = par_rd;
            x_in = par_rd;
            par_ra = par_rd;
         end
         plcl_pkg::ST_LAB_START: begin
            if (k_lt_n) begin
               x_in = k_i;
               par_ra = k_i;
               fret_in = plcl_pkg::FR_K;
            end else begin
               total_in = TOT_W'(n_ff);
               clusters_in = cnt_ff;
            end
         end
         plcl_pkg::ST_LAB_RD: begin
            lab_we = 1'b1;
            lab_wa = k_i;
            if (root_ff == k_i) begin
               lab_wd = cnt_ff[IW-1:0];
               sum_we = 1'b1;
               sum_wa = cnt_ff[IW-1:0];
               sum_wd = v_now;
               cnt_in = cnt_ff + NW'(1);
               k_in = k_ff + NW'(1);
            end else begin
               lab_wd = lab_rd;
               sum_ra = lab_rd;
               lbl_in = lab_rd;
               v_in = val_rd;
            end
         end
         plcl_pkg::ST_LAB_SUM: begin
            sum_we = 1'b1;
            sum_wa = lbl_ff;
            sum_wd = sum_rd + v_old;
            k_in = k_ff + NW'(1);
         end
         default: begin
         end
      endcase

      // Root search start and return, and the step to the next bond or site.
      if ((state_ff == plcl_pkg::ST_JOIN) && join_ok) begin
         x_in = ja_i;
         par_ra = ja_i;
         fret_in = plcl_pkg::FR_A;
      end
      if (state_ff == plcl_pkg::ST_FIND_P) begin
         if (!root_hit) begin
            par_ra = par_rd;
         end else begin
            case (fret_ff)
               plcl_pkg::FR_A: begin
                  ra_in = x_ff;
                  x_in = jb_i;
                  par_ra = jb_i;
                  fret_in = plcl_pkg::FR_B;
               end
               plcl_pkg::FR_B: begin
                  // The smaller root becomes the parent, so each root is its set's minimum.
                  if (ra_ff < x_ff) begin
                     par_we = 1'b1;
                     par_wa = x_ff;
                     par_wd = ra_ff;
                  end else if (x_ff < ra_ff) begin
                     par_we = 1'b1;
                     par_wa = ra_ff;
                     par_wd = x_ff;
                  end
               end
               default: begin
                  root_in = x_ff;
                  lab_ra = x_ff;
                  val_ra = k_i;
               end
            endcase
         end
      end
      if (((state_ff == plcl_pkg::ST_JOIN) && !join_ok) ||
          ((state_ff == plcl_pkg::ST_FIND_P) && root_hit && (fret_ff == plcl_pkg::FR_B))) begin
         if (!bsel_ff) begin
            bsel_in = 1'b1;
         end else begin
            bsel_in = 1'b0;
            if (!col_last) begin
               col_in = col_next;
            end else begin
               col_in = '0;
               if (row_last) begin
                  k_in = '0;
                  cnt_in = '0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
                  base_r_in = base_r_ff + SITE_W'(COLS);
                  base_n_in = (row_ff == ROW_W'(ROWS - 2)) ? '0 :
                              base_n_ff + SITE_W'(COLS);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plcl_pkg::ST_IDLE;
         load_ptr_ff <= '0;
         total_ff <= '0;
         clusters_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_ptr_ff <= load_ptr_in;
         total_ff <= total_in;
         clusters_ff <= clusters_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fret_ff <= fret_in;
      n_ff <= n_in;
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      row_ff <= row_in;
      col_ff <= col_in;
      base_r_ff <= base_r_in;
      base_n_ff <= base_n_in;
      bsel_ff <= bsel_in;
      rj_ff <= rj_in;
      nj_ff <= nj_in;
      rjn_ff <= rjn_in;
      njn_ff <= njn_in;
      x_ff <= x_in;
      ra_ff <= ra_in;
      root_ff <= root_in;
      lbl_ff <= lbl_in;
      v_ff <= v_in;
      mode_ff <= mode_in;
      q_ff <= q_in;
      spin2_ff <= spin2_in;
      pend_label_ff <= pend_label_in;
      pend_sum_ff <= pend_sum_in;
      rsp_count_ff <= rsp_count_in;
      rsp_label_ff <= rsp_label_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   plcl_ram #(.WIDTH(SINFO_W), .DEPTH(NSITES)) u_site_ram (
      .clock(clock), .wr_en(site_we), .wr_addr(site_wa), .wr_data(site_wd),
      .rd_addr(site_ra), .rd_data(site_rd)
   );

   plcl_ram #(.WIDTH(1), .DEPTH(MAX_SPINS)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_addr(val_ra), .rd_data(val_rd)
   );

   plcl_ram #(.WIDTH(IW), .DEPTH(MAX_SPINS)) u_par_ram (
      .clock(clock), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_addr(par_ra), .rd_data(par_rd)
   );

   plcl_ram #(.WIDTH(IW), .DEPTH(MAX_SPINS)) u_lab_ram (
      .clock(clock), .wr_en(lab_we), .wr_addr(lab_wa), .wr_data(lab_wd),
      .rd_addr(lab_ra), .rd_data(lab_rd)
   );

   plcl_ram #(.WIDTH(SUMW), .DEPTH(MAX_SPINS)) u_sum_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_wa), .wr_data(sum_wd),
      .rd_addr(sum_ra), .rd_data(sum_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cluster_count = rsp_count_ff;
   assign rsp_spin_label = rsp_label_ff;
   assign rsp_cluster_sum = rsp_sum_ff;

endmodule

[rtl/plcl_checker.sv]
module plcl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_mode,
   input logic              req_merged,
   input logic              req_spin_first,
   input logic              req_spin_second,
   input logic              req_bond_even,
   input logic              req_bond_odd,
   input logic [6:0]        req_query_index,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [6:0]        rsp_cluster_count,
   input logic [6:0]        rsp_spin_label,
   input logic signed [7:0] rsp_cluster_sum
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cluster_count) &&
      $stable(rsp_spin_label) && $stable(rsp_cluster_sum))
      else $error("result beat changed while stalled");

   // A load never produces a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == plcl_pkg::MODE_LOAD) |=> !$rose(rsp_valid))
      else $error("result appeared after a load");

   // A query occupies the block while its memory read is in flight.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      ((req_mode == plcl_pkg::MODE_LABEL) || (req_mode == plcl_pkg::MODE_SUM))
      |=> !req_ready)
      else $error("block took a command during a query read");

   // A nonzero cluster sum needs at least one cluster.
   a_sum_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cluster_sum != 8'sd0) |-> (rsp_cluster_count != 7'd0))
      else $error("cluster sum reported with no clusters");

endmodule

bind periodic_lattice_cluster_labeler plcl_checker u_plcl_checker (.*);

[verif/periodic_lattice_cluster_labeler_test.sv]
`timescale 1ns / 100ps

module periodic_lattice_cluster_labeler_test;

   localparam int ROWS = 10;
   localparam int COLS = 6;
   localparam int MAX_SPINS = 120;
   localparam int NSITES = ROWS * COLS;
   localparam int RANDOM_ITEMS = 1700;
   localparam int STALL_LIMIT = 50000;
   localparam int QUERY_W = plcl_pkg::QUERY_W;
   localparam int COUNT_W = plcl_pkg::COUNT_W;
   localparam int LABEL_W = plcl_pkg::LABEL_W;
   localparam int SUM_W = plcl_pkg::SUM_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = plcl_pkg::MODE_LABEL;
   logic req_merged = 1'b0;
   logic req_spin_first = 1'b0;
   logic req_spin_second = 1'b0;
   logic req_bond_even = 1'b0;
   logic req_bond_odd = 1'b0;
   logic [QUERY_W-1:0] req_query_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [COUNT_W-1:0] rsp_cluster_count;
   logic [LABEL_W-1:0] rsp_spin_label;
   logic signed [SUM_W-1:0] rsp_cluster_sum;

   periodic_lattice_cluster_labeler #(
      .ROWS(ROWS), .COLS(COLS), .MAX_SPINS(MAX_SPINS)
   ) uut (.*);

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [LABEL_W-1:0] label;
      logic signed [SUM_W-1:0] sum;
   } answer_t;

   typedef struct {
      logic [1:0] mode;
      logic merged, s1, s2, be, bo;
      logic [QUERY_W-1:0] q;
      int repeats;
      bit typed;
      answer_t want;
   } stim_row_t;

   answer_t pending_answers[$];
   int errors = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int items_sent = 0;

   // Shadow copy of the lattice and cluster tables.
   logic site_merged_m[NSITES];
   logic [1:0] site_bonds_m[NSITES];
   logic spin_value_m[MAX_SPINS];
   int parent_m[MAX_SPINS];
   int label_m[MAX_SPINS];
   int csum_m[MAX_SPINS];
   int load_ptr = 0;
   int spins_loaded = 0;
   int clusters = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int root_of(int x);
      while (parent_m[x] != x) begin
         parent_m[x] = parent_m[parent_m[x]];
         x = parent_m[x];
      end
      return x;
   endfunction

   function automatic void join_spins(int a, int b, int n);
      int ra, rb;
      if (a >= n || b >= n) return;
      ra = root_of(a);
      rb = root_of(b);
      if (ra < rb) parent_m[rb] = ra;
      else if (rb < ra) parent_m[ra] = rb;
   endfunction

   function automatic void label_clusters();
      int first[NSITES];
      int idx, n, nr, jn, s, root, v;
      idx = 0;
      for (int i = 0; i < NSITES; i++) begin
         first[i] = idx;
         idx += site_merged_m[i] ? 1 : 2;
      end
      n = idx < MAX_SPINS ? idx : MAX_SPINS;
      for (int k = 0; k < n; k++) parent_m[k] = k;
      for (int r = 0; r < ROWS; r++) begin
         nr = (r + 1) % ROWS;
         for (int j = 0; j < COLS; j++) begin
            jn = (j + 1) % COLS;
            s = r * COLS + j;
            // A is a site's first spin, B its second (same as A when merged).
            if (r % 2 == 0) begin
               if (site_bonds_m[s][0])
                  join_spins(first[nr*COLS+j], first[s] + (site_merged_m[s] ? 0 : 1), n);
               if (site_bonds_m[s][1])
                  join_spins(first[nr*COLS+j] + (site_merged_m[nr*COLS+j] ? 0 : 1),
                             first[r*COLS+jn], n);
            end else begin
               if (site_bonds_m[s][0])
                  join_spins(first[nr*COLS+j] + (site_merged_m[nr*COLS+j] ? 0 : 1),
                             first[s], n);
               if (site_bonds_m[s][1])
                  join_spins(first[s] + (site_merged_m[s] ? 0 : 1),
                             first[nr*COLS+jn], n);
            end
         end
      end
      clusters = 0;
      for (int k = 0; k < n; k++) begin
         root = root_of(k);
         v = spin_value_m[k] ? -1 : 1;
         if (root == k) begin
            label_m[k] = clusters;
            csum_m[clusters] = v;
            clusters++;
         end else begin
            label_m[k] = label_m[root];
            csum_m[label_m[k]] += v;
         end
      end
      spins_loaded = n;
   endfunction

   // Steps the shadow state; returns 1 when the command produces a result.
   function automatic bit apply_command(logic [1:0] mode, logic merged, logic s1, logic s2,
                                        logic be, logic bo, logic [QUERY_W-1:0] q,
                                        output answer_t ans);
      int sum;
      ans = '0;
      sum = 0;
      case (mode)
         plcl_pkg::MODE_LOAD: begin
            if (load_ptr == 0) spins_loaded = 0;
            site_merged_m[load_ptr] = merged;
            site_bonds_m[load_ptr] = {bo, be};
            if (spins_loaded < MAX_SPINS) spin_value_m[spins_loaded] = s1;
            spins_loaded++;
            if (!merged) begin
               if (spins_loaded < MAX_SPINS) spin_value_m[spins_loaded] = s2;
               spins_loaded++;
            end
            load_ptr = (load_ptr + 1 >= NSITES) ? 0 : load_ptr + 1;
            return 1'b0;
         end
         plcl_pkg::MODE_COMPUTE: begin
            if (load_ptr == 0) label_clusters();
         end
         plcl_pkg::MODE_LABEL: begin
            if (q < spins_loaded && q < MAX_SPINS) ans.label = LABEL_W'(label_m[q]);
         end
         default: begin
            if (q < clusters) sum = csum_m[q];
            if (sum > 127) sum = 127;
            if (sum < -128) sum = -128;
            ans.sum = SUM_W'(sum);
         end
      endcase
      ans.count = COUNT_W'(clusters);
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_command(logic [1:0] mode, logic merged, logic s1, logic s2,
                               logic be, logic bo, logic [QUERY_W-1:0] q,
                               bit typed = 1'b0, answer_t want = '0);
      answer_t ans;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_merged <= merged;
      req_spin_first <= s1;
      req_spin_second <= s2;
      req_bond_even <= be;
      req_bond_odd <= bo;
      req_query_index <= q;
      do @(posedge clock); while (!req_ready);
      if (apply_command(mode, merged, s1, s2, be, bo, q, ans))
         pending_answers.push_back(typed ? want : ans);
      items_sent++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected beat, count", rsp_cluster_count, -1);
         end else begin
            answer_t exp_ans;
            exp_ans = pending_answers.pop_front();
            if (rsp_cluster_count !== exp_ans.count)
               report_mismatch("cluster_count", rsp_cluster_count, exp_ans.count);
            if (rsp_spin_label !== exp_ans.label)
               report_mismatch("spin_label", rsp_spin_label, exp_ans.label);
            if (rsp_cluster_sum !== exp_ans.sum)
               report_mismatch("cluster_sum", rsp_cluster_sum, exp_ans.sum);
         end
      end
   end

   stim_row_t directed[] = '{
      // Queries before any lattice read as zero.
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd0, 1, 1, '{7'd0, 7'd0, 8'sd0}},
      '{plcl_pkg::MODE_SUM, 0, 0, 0, 0, 0, 7'd0, 1, 1, '{7'd0, 7'd0, 8'sd0}},
      // Full lattice of split sites with no bonds: every spin is its own cluster.
      '{plcl_pkg::MODE_LOAD, 0, 0, 1, 0, 0, 7'd0, NSITES, 0, '0},
      '{plcl_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, 7'd0, 1, 1, '{7'd120, 7'd0, 8'sd0}},
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd119, 1, 1, '{7'd120, 7'd119, 8'sd0}},
      '{plcl_pkg::MODE_SUM, 0, 0, 0, 0, 0, 7'd0, 1, 1, '{7'd120, 7'd0, 8'sd1}},
      '{plcl_pkg::MODE_SUM, 0, 0, 0, 0, 0, 7'd1, 1, 1, '{7'd120, 7'd0, -8'sd1}},
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd127, 1, 1, '{7'd120, 7'd0, 8'sd0}},
      '{plcl_pkg::MODE_SUM, 0, 0, 0, 0, 0, 7'd120, 1, 1, '{7'd120, 7'd0, 8'sd0}},
      // Merged sites with every bond set.
      '{plcl_pkg::MODE_LOAD, 1, 1, 0, 1, 1, 7'd0, NSITES, 0, '0},
      '{plcl_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, 7'd0, 1, 0, '0},
      '{plcl_pkg::MODE_SUM, 0, 0, 0, 0, 0, 7'd0, 1, 0, '0},
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd59, 1, 0, '0},
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd60, 1, 0, '0},
      // Compute in the middle of a load only reports the old count.
      '{plcl_pkg::MODE_LOAD, 0, 1, 1, 1, 0, 7'd0, 7, 0, '0},
      '{plcl_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, 7'd0, 1, 0, '0},
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd13, 1, 0, '0},
      '{plcl_pkg::MODE_LOAD, 0, 0, 0, 0, 1, 7'd0, NSITES - 7, 0, '0},
      '{plcl_pkg::MODE_COMPUTE, 0, 0, 0, 0, 0, 7'd0, 1, 0, '0},
      '{plcl_pkg::MODE_SUM, 0, 0, 0, 0, 0, 7'd127, 1, 0, '0},
      '{plcl_pkg::MODE_LABEL, 0, 0, 0, 0, 0, 7'd64, 1, 0, '0}
   };

   task automatic random_query();
      logic [QUERY_W-1:0] q;
      q = ($urandom_range(3) == 0) ? QUERY_W'($urandom) : QUERY_W'($urandom_range(119));
      send_command($urandom_range(1) ? plcl_pkg::MODE_LABEL : plcl_pkg::MODE_SUM,
                   1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), q);
   endtask

   initial begin
      int phase_idle[4] = '{0, 70, 0, 30};
      int phase_stall[4] = '{0, 0, 70, 30};
      int merge_pct, bond_pct, first_item;
      for (int i = 0; i < MAX_SPINS; i++) label_m[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         for (int r = 0; r < directed[i].repeats; r++)
            send_command(directed[i].mode, directed[i].merged, directed[i].s1,
                         directed[i].s2, directed[i].be, directed[i].bo,
                         directed[i].q, directed[i].typed, directed[i].want);

      // Long hold-off on results while queries keep arriving.
      hold_left = 400;
      for (int i = 0; i < 40; i++) random_query();
      go_quiet();

      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         int ph;
         ph = (items_sent - first_item) * 4 / RANDOM_ITEMS;
         idle_pct = phase_idle[ph];
         stall_pct = phase_stall[ph];
         merge_pct = $urandom_range(100);
         bond_pct = $urandom_range(100);
         // One lattice: mostly clean loads, sometimes a query or early compute
         // slipped in between sites.
         for (int s = 0; s < NSITES; s++) begin
            if ($urandom_range(99) < 4) begin
               if ($urandom_range(1)) random_query();
               else send_command(plcl_pkg::MODE_COMPUTE, 1'($urandom), 1'($urandom),
                                 1'($urandom), 1'($urandom), 1'($urandom),
                                 QUERY_W'($urandom));
            end
            send_command(plcl_pkg::MODE_LOAD, $urandom_range(99) < merge_pct,
                         1'($urandom), 1'($urandom),
                         $urandom_range(99) < bond_pct, $urandom_range(99) < bond_pct,
                         QUERY_W'($urandom));
         end
         send_command(plcl_pkg::MODE_COMPUTE, 1'($urandom), 1'($urandom), 1'($urandom),
                      1'($urandom), 1'($urandom), QUERY_W'($urandom));
         repeat ($urandom_range(14, 4)) random_query();
         if ($urandom_range(9) == 0) go_quiet();
      end

      go_quiet();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
